// File: src/ffm_pkg.sv
// ----------------------------------------------------------------------------
// ffm_pkg: failsafe monitor shared types and constants
// Holds the tick and result payload types, the mode codes, the register map,
// the register reset values, the register set and the carried monitor state.
// ----------------------------------------------------------------------------
`default_nettype none

package ffm_pkg;

	// Flight mode codes as they appear on the result channel
	typedef enum logic [1:0] {
		MODE_NOMINAL = 2'd0,
		MODE_HOVER   = 2'd1,
		MODE_DESCENT = 2'd2,
		MODE_ABORT   = 2'd3
	} mode_t;

	// Configuration register map
	localparam int unsigned CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SENSOR_TIMEOUT   = 3'd0;
	localparam cfg_idx_t CFG_ATTITUDE_RECOVER = 3'd1;
	localparam cfg_idx_t CFG_MAX_ROLL         = 3'd2;
	localparam cfg_idx_t CFG_MAX_PITCH        = 3'd3;
	localparam cfg_idx_t CFG_POSITION_BOUND   = 3'd4;
	localparam cfg_idx_t CFG_ALTITUDE_HIGH    = 3'd5;
	localparam cfg_idx_t CFG_ALTITUDE_LOW     = 3'd6;

	// Register reset values
	localparam logic        [31:0] RST_SENSOR_TIMEOUT   = 32'd500000;
	localparam logic        [31:0] RST_ATTITUDE_RECOVER = 32'd1000000;
	localparam logic        [14:0] RST_MAX_ROLL         = 15'd6434;
	localparam logic        [14:0] RST_MAX_PITCH        = 15'd6434;
	localparam logic        [30:0] RST_POSITION_BOUND   = 31'd6553600;
	localparam logic signed [31:0] RST_ALTITUDE_HIGH    = 32'sd6553600;
	localparam logic signed [31:0] RST_ALTITUDE_LOW     = -32'sd65536;

	// Configuration register set
	typedef struct packed {
		logic        [31:0] sensor_timeout_us;
		logic        [31:0] attitude_recovery_us;
		logic        [14:0] max_roll;
		logic        [14:0] max_pitch;
		logic        [30:0] position_bound;
		logic signed [31:0] altitude_high;
		logic signed [31:0] altitude_low;
	} cfg_t;

	// One input tick
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               imu_ok;
		logic               state_ok;
		logic        [15:0] dt_us;
	} tick_t;

	// One result item
	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [15:0] target_yaw;
	} result_t;

	// Monitor state carried from tick to tick
	typedef struct packed {
		logic        abort;
		logic [31:0] sensor_loss_time;
		logic [31:0] attitude_violation_time;
	} mon_state_t;

endpackage

`default_nettype wire

// File: src/ffm_cfg.sv
// ----------------------------------------------------------------------------
// ffm_cfg: configuration register file
// Seven threshold registers written through a valid/ready port that is
// always ready. Writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ffm_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire ffm_pkg::cfg_idx_t cfg_index,
	input  wire logic [31:0]       cfg_data,
	output      ffm_pkg::cfg_t     cfg
);

	ffm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register write on each completed transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_timeout_us    <= ffm_pkg::RST_SENSOR_TIMEOUT;
			cfg_q.attitude_recovery_us <= ffm_pkg::RST_ATTITUDE_RECOVER;
			cfg_q.max_roll             <= ffm_pkg::RST_MAX_ROLL;
			cfg_q.max_pitch            <= ffm_pkg::RST_MAX_PITCH;
			cfg_q.position_bound       <= ffm_pkg::RST_POSITION_BOUND;
			cfg_q.altitude_high        <= ffm_pkg::RST_ALTITUDE_HIGH;
			cfg_q.altitude_low         <= ffm_pkg::RST_ALTITUDE_LOW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffm_pkg::CFG_SENSOR_TIMEOUT:   cfg_q.sensor_timeout_us    <= cfg_data;
				ffm_pkg::CFG_ATTITUDE_RECOVER: cfg_q.attitude_recovery_us <= cfg_data;
				ffm_pkg::CFG_MAX_ROLL:         cfg_q.max_roll             <= cfg_data[14:0];
				ffm_pkg::CFG_MAX_PITCH:        cfg_q.max_pitch            <= cfg_data[14:0];
				ffm_pkg::CFG_POSITION_BOUND:   cfg_q.position_bound       <= cfg_data[30:0];
				ffm_pkg::CFG_ALTITUDE_HIGH:    cfg_q.altitude_high        <= $signed(cfg_data);
				ffm_pkg::CFG_ALTITUDE_LOW:     cfg_q.altitude_low         <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/ffm_step.sv
// ----------------------------------------------------------------------------
// ffm_step: per-tick failsafe decision
// Checks the position box, runs the two saturating timers and picks the mode
// and target for one registered tick. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ffm_step (
	input  wire ffm_pkg::tick_t      tick,
	input  wire ffm_pkg::cfg_t       cfg,
	input  wire ffm_pkg::mon_state_t cur,
	output      ffm_pkg::mon_state_t nxt,
	output      ffm_pkg::result_t    result
);

	logic [31:0] abs_x;
	logic [31:0] abs_y;
	logic [15:0] abs_roll;
	logic [15:0] abs_pitch;
	logic        out_of_box;
	logic        tilted;
	logic [32:0] sens_sum;
	logic [32:0] att_sum;
	logic [31:0] sens_next;
	logic [31:0] att_next;
	ffm_pkg::mode_t mode;

	// Magnitudes; the most negative value maps to 2^31 / 2^15 unsigned
	assign abs_x     = tick.pos_x[31] ? 32'(-tick.pos_x) : tick.pos_x;
	assign abs_y     = tick.pos_y[31] ? 32'(-tick.pos_y) : tick.pos_y;
	assign abs_roll  = tick.roll[15]  ? 16'(-tick.roll)  : tick.roll;
	assign abs_pitch = tick.pitch[15] ? 16'(-tick.pitch) : tick.pitch;

	// Allowed box
	assign out_of_box = (abs_x > {1'b0, cfg.position_bound})
		|| (abs_y > {1'b0, cfg.position_bound})
		|| (tick.pos_z > cfg.altitude_high)
		|| (tick.pos_z < cfg.altitude_low);

	assign tilted = (abs_roll > {1'b0, cfg.max_roll})
		|| (abs_pitch > {1'b0, cfg.max_pitch});

	// Saturating timer updates
	assign sens_sum  = {1'b0, cur.sensor_loss_time} + {17'd0, tick.dt_us};
	assign att_sum   = {1'b0, cur.attitude_violation_time} + {17'd0, tick.dt_us};
	assign sens_next = tick.imu_ok ? 32'd0 : (sens_sum[32] ? '1 : sens_sum[31:0]);
	assign att_next  = !tilted ? 32'd0 : (att_sum[32] ? '1 : att_sum[31:0]);

	// Mode selection; abort latches and freezes the timers
	always_comb begin
		nxt = cur;
		if (!tick.state_ok || out_of_box || cur.abort) begin
			nxt.abort = 1'b1;
			mode      = ffm_pkg::MODE_ABORT;
		end else begin
			nxt.sensor_loss_time        = sens_next;
			nxt.attitude_violation_time = att_next;
			if (sens_next > cfg.sensor_timeout_us) begin
				mode = ffm_pkg::MODE_DESCENT;
			end else if (att_next > cfg.attitude_recovery_us) begin
				mode = ffm_pkg::MODE_HOVER;
			end else begin
				mode = ffm_pkg::MODE_NOMINAL;
			end
		end
	end

	// Target: hold position, land in place during descent
	always_comb begin
		result.mode     = mode;
		result.target_x = tick.pos_x;
		result.target_y = tick.pos_y;
		if (mode == ffm_pkg::MODE_DESCENT) begin
			result.target_z   = '0;
			result.target_yaw = '0;
		end else begin
			result.target_z   = tick.pos_z;
			result.target_yaw = tick.yaw;
		end
	end

endmodule

`default_nettype wire

// File: src/flight_failsafe_monitor.sv
// ----------------------------------------------------------------------------
// flight_failsafe_monitor: per-tick failsafe mode selector
// Input register, one pass of decision logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   tick channel: one tick (position, attitude, validity flags, dt) per
//   transfer, taken when tick_valid is high and tick_stall is low.
//   result channel: one result (mode and target) per tick, in order, taken
//   when result_valid is high and result_stall is low.
//   cfg channel: register writes, always ready; write only while no tick is
//   in flight.
//   Path: a tick taken into the tick register goes through the decision
//   logic into the result register (two registers). Throughput: one tick per
//   cycle while the receiver does not stall, set by the single decision pass.
//   Reset clears both timers, the abort latch and the valid flags and loads
//   the register defaults. Abort, once entered, holds until reset.
//   When the receiver stalls the result register holds its item; the tick
//   register still takes one more tick if it is empty, then tick_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_failsafe_monitor (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick_valid,
	output      logic              tick_stall,
	input  wire ffm_pkg::tick_t    tick,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      ffm_pkg::result_t  result,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire ffm_pkg::cfg_idx_t cfg_index,
	input  wire logic [31:0]       cfg_data
);

	ffm_pkg::cfg_t       cfg;
	ffm_pkg::tick_t      tick_s1;
	logic                valid_s1;
	ffm_pkg::result_t    result_q;
	logic                result_valid_q;
	ffm_pkg::mon_state_t state_q;
	ffm_pkg::mon_state_t state_nxt;
	ffm_pkg::result_t    result_nxt;
	logic                out_free;
	logic                s1_go;
	logic                accept;

	ffm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffm_step u_step (
		.tick   (tick_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	// Flow control
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_go      = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign accept     = tick_valid && !tick_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Valid flags and monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			state_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				result_valid_q <= s1_go;
			end
			if (s1_go) begin
				state_q <= state_nxt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
		if (s1_go) begin
			result_q <= result_nxt;
		end
	end

endmodule

`default_nettype wire

// File: src/ffm_checker.sv
// ----------------------------------------------------------------------------
// ffm_checker: port-level checks for the failsafe monitor
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              tick_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire ffm_pkg::result_t  result
);

	// Abort latches: the result after an abort transfer is abort as well
	a_abort_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.mode == ffm_pkg::MODE_ABORT)
		|=> (!result_valid || result.mode == ffm_pkg::MODE_ABORT))
		else $error("abort mode was left without reset");

	// Descent lands in place with yaw zeroed
	a_descent_target: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mode == ffm_pkg::MODE_DESCENT)
		|-> (result.target_z == '0 && result.target_yaw == '0))
		else $error("descent target altitude or yaw not zero");

	// Input backs up only while a finished result is held by the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (result_valid && result_stall))
		else $error("tick stalled with the result register free");

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or was dropped");

endmodule

bind flight_failsafe_monitor ffm_checker u_ffm_checker (.*);

`default_nettype wire

// File: verif/tb_flight_failsafe_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flight_failsafe_monitor: self-checking bench for the failsafe monitor
// Drives ticks with random sender gaps and receiver stalls and writes the
// register set between phases. A shadow copy of the timers and the mode latch
// predicts every result, and each result is checked field by field in order.
// Phases: reset values, directed threshold and priority ticks, a long timer
// run at maximum thresholds, random phases over several register settings,
// and abort entry last, since abort holds until reset.
// ----------------------------------------------------------------------------

module tb_flight_failsafe_monitor;

	localparam int CLK_PERIOD = 20;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_TICKS = 270;
	// run of the largest dt with IMU lost and roll over the limit
	localparam int SOAK_TICKS = 40;
	localparam int END_CYCLES = 10;

	localparam ffm_pkg::cfg_t CFG_AT_RESET = '{
		sensor_timeout_us:    ffm_pkg::RST_SENSOR_TIMEOUT,
		attitude_recovery_us: ffm_pkg::RST_ATTITUDE_RECOVER,
		max_roll:             ffm_pkg::RST_MAX_ROLL,
		max_pitch:            ffm_pkg::RST_MAX_PITCH,
		position_bound:       ffm_pkg::RST_POSITION_BOUND,
		altitude_high:        ffm_pkg::RST_ALTITUDE_HIGH,
		altitude_low:         ffm_pkg::RST_ALTITUDE_LOW
	};

	typedef enum int {
		CAUSE_STATE_BAD,
		CAUSE_X_MOST_NEG,
		CAUSE_Y_OUT,
		CAUSE_Z_HIGH,
		CAUSE_Z_LOW,
		CAUSE_CROSSED_WINDOW
	} abort_cause_t;

	// Shadow of the monitor: registers, timers, mode latch and the results due
	class failsafe_mirror;
		ffm_pkg::cfg_t    regs;
		logic [31:0]      loss_us;
		logic [31:0]      tilt_us;
		ffm_pkg::mode_t   mode_now;
		ffm_pkg::result_t awaited_results[$];
		int unsigned      n_checked;
		int unsigned      n_errors;
		int unsigned      mode_count[4];

		function new();
			regs = CFG_AT_RESET;
			loss_us = '0;
			tilt_us = '0;
			mode_now = ffm_pkg::MODE_NOMINAL;
			n_checked = 0;
			n_errors = 0;
			mode_count = '{0, 0, 0, 0};
		endfunction

		function void set_reg(ffm_pkg::cfg_idx_t idx, logic [31:0] d);
			case (idx)
				ffm_pkg::CFG_SENSOR_TIMEOUT:   regs.sensor_timeout_us = d;
				ffm_pkg::CFG_ATTITUDE_RECOVER: regs.attitude_recovery_us = d;
				ffm_pkg::CFG_MAX_ROLL:         regs.max_roll = d[14:0];
				ffm_pkg::CFG_MAX_PITCH:        regs.max_pitch = d[14:0];
				ffm_pkg::CFG_POSITION_BOUND:   regs.position_bound = d[30:0];
				ffm_pkg::CFG_ALTITUDE_HIGH:    regs.altitude_high = d;
				ffm_pkg::CFG_ALTITUDE_LOW:     regs.altitude_low = d;
				default: ;
			endcase
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {17'd0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		// Advance the shadow state by one accepted tick and queue its result
		function void log_tick(ffm_pkg::tick_t t);
			logic [32:0]      mx, my;
			logic [16:0]      mr, mp;
			logic             out_box, tilted;
			ffm_pkg::result_t e;
			mx = t.pos_x[31] ? 33'd0 - {1'b1, t.pos_x} : {1'b0, t.pos_x};
			my = t.pos_y[31] ? 33'd0 - {1'b1, t.pos_y} : {1'b0, t.pos_y};
			mr = t.roll[15] ? 17'd0 - {1'b1, t.roll} : {1'b0, t.roll};
			mp = t.pitch[15] ? 17'd0 - {1'b1, t.pitch} : {1'b0, t.pitch};
			out_box = mx > {2'b00, regs.position_bound}
				|| my > {2'b00, regs.position_bound}
				|| $signed(t.pos_z) > $signed(regs.altitude_high)
				|| $signed(t.pos_z) < $signed(regs.altitude_low);
			if (!t.state_ok || out_box) begin
				mode_now = ffm_pkg::MODE_ABORT;
			end else if (mode_now != ffm_pkg::MODE_ABORT) begin
				loss_us = t.imu_ok ? 32'd0 : sat_add(loss_us, t.dt_us);
				tilted = mr > {2'b00, regs.max_roll} || mp > {2'b00, regs.max_pitch};
				tilt_us = tilted ? sat_add(tilt_us, t.dt_us) : 32'd0;
				if (loss_us > regs.sensor_timeout_us)
					mode_now = ffm_pkg::MODE_DESCENT;
				else if (tilt_us > regs.attitude_recovery_us)
					mode_now = ffm_pkg::MODE_HOVER;
				else
					mode_now = ffm_pkg::MODE_NOMINAL;
			end
			e.mode = mode_now;
			e.target_x = t.pos_x;
			e.target_y = t.pos_y;
			e.target_z = t.pos_z;
			e.target_yaw = t.yaw;
			// descent brings the vehicle down: no altitude, no heading
			if (mode_now == ffm_pkg::MODE_DESCENT) begin
				e.target_z = '0;
				e.target_yaw = '0;
			end
			awaited_results.push_back(e);
		endfunction

		function void check_result(ffm_pkg::result_t r);
			ffm_pkg::result_t e;
			if (awaited_results.size() == 0) begin
				$error("result with no tick outstanding: mode %0d", r.mode);
				n_errors++;
				return;
			end
			e = awaited_results.pop_front();
			n_checked++;
			mode_count[e.mode]++;
			if (r.mode !== e.mode) begin
				$error("mode: expected %0d, actual %0d", e.mode, r.mode);
				n_errors++;
			end
			if (r.target_x !== e.target_x) begin
				$error("target_x: expected %0d, actual %0d", e.target_x, r.target_x);
				n_errors++;
			end
			if (r.target_y !== e.target_y) begin
				$error("target_y: expected %0d, actual %0d", e.target_y, r.target_y);
				n_errors++;
			end
			if (r.target_z !== e.target_z) begin
				$error("target_z: expected %0d, actual %0d", e.target_z, r.target_z);
				n_errors++;
			end
			if (r.target_yaw !== e.target_yaw) begin
				$error("target_yaw: expected %0d, actual %0d", e.target_yaw, r.target_yaw);
				n_errors++;
			end
		endfunction

		function int unsigned results_due();
			return awaited_results.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              tick_valid;
	logic              tick_stall;
	ffm_pkg::tick_t    tick_bus;
	logic              result_valid;
	logic              result_stall;
	ffm_pkg::result_t  result_bus;
	logic              cfg_valid;
	logic              cfg_ready;
	ffm_pkg::cfg_idx_t cfg_index;
	logic [31:0]       cfg_data;

	failsafe_mirror mirror;
	int unsigned    send_idle_pct;
	int unsigned    stall_pct;
	int unsigned    hold_request;
	int unsigned    hold_left;
	int unsigned    quiet_cycles;
	bit             imu_down;
	bit             tilt_on;

	flight_failsafe_monitor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			mirror.check_result(result_bus);
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic ffm_pkg::tick_t mk_tick(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [15:0] r, input logic [15:0] p,
			input logic [15:0] w, input bit imu, input bit state, input logic [15:0] dt);
		ffm_pkg::tick_t t;
		t.pos_x = x;
		t.pos_y = y;
		t.pos_z = z;
		t.roll = r;
		t.pitch = p;
		t.yaw = w;
		t.imu_ok = imu;
		t.state_ok = state;
		t.dt_us = dt;
		return t;
	endfunction

	// Horizontal coordinate inside +/- bound, edges favored
	function automatic logic [31:0] pick_coord(input logic [30:0] b);
		logic [31:0] m;
		case ($urandom_range(0, 7))
			0: m = {1'b0, b};
			1: m = '0;
			default: m = $urandom_range(32'(b));
		endcase
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Angle within the limit, or beyond it when over is set
	function automatic logic [15:0] pick_angle(input logic [14:0] lim, input bit over);
		logic [15:0] m;
		if (over && (lim == 15'h7FFF || $urandom_range(0, 3) == 0))
			return 16'h8000;
		if (over)
			m = 16'($urandom_range(32767, 32'(lim) + 1));
		else
			m = 16'($urandom_range(32'(lim)));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Random tick: IMU dropouts and tilt come in runs so the timers build up;
	// the noisy form also throws bad state and out-of-box positions
	function automatic ffm_pkg::tick_t random_tick(input bit noisy);
		ffm_pkg::tick_t t;
		int unsigned    which;
		logic [31:0]    span;
		if ($urandom_range(0, 7) == 0)
			imu_down = !imu_down;
		if ($urandom_range(0, 7) == 0)
			tilt_on = !tilt_on;
		which = tilt_on ? $urandom_range(1, 3) : 0;
		t.pos_x = pick_coord(mirror.regs.position_bound);
		t.pos_y = pick_coord(mirror.regs.position_bound);
		span = mirror.regs.altitude_high - mirror.regs.altitude_low;
		case ($urandom_range(0, 7))
			0: t.pos_z = mirror.regs.altitude_high;
			1: t.pos_z = mirror.regs.altitude_low;
			default: t.pos_z = mirror.regs.altitude_low + $urandom_range(span);
		endcase
		t.roll = pick_angle(mirror.regs.max_roll, which[0]);
		t.pitch = pick_angle(mirror.regs.max_pitch, which[1]);
		t.yaw = 16'($urandom);
		t.imu_ok = !imu_down ^ ($urandom_range(0, 19) == 0);
		t.state_ok = 1'b1;
		case ($urandom_range(0, 9))
			0: t.dt_us = '0;
			1: t.dt_us = '1;
			default: t.dt_us = 16'($urandom_range(65535));
		endcase
		if (noisy) begin
			if ($urandom_range(0, 3) == 0)
				t.pos_x = $urandom;
			if ($urandom_range(0, 3) == 0)
				t.pos_z = $urandom;
			t.state_ok = ($urandom_range(0, 7) != 0);
		end
		return t;
	endfunction

	function automatic ffm_pkg::cfg_t random_config();
		ffm_pkg::cfg_t c;
		logic [31:0]   a, b;
		a = $urandom;
		b = $urandom;
		c.sensor_timeout_us = $urandom_range(400000);
		c.attitude_recovery_us = $urandom_range(400000);
		c.max_roll = 15'($urandom);
		c.max_pitch = 15'($urandom);
		c.position_bound = 31'($urandom);
		c.altitude_high = ($signed(a) > $signed(b)) ? a : b;
		c.altitude_low = ($signed(a) > $signed(b)) ? b : a;
		return c;
	endfunction

	// One tick transfer, with an optional random gap before it
	task automatic send_tick(input ffm_pkg::tick_t t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_bus <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		mirror.log_tick(t);
	endtask

	// Stop offering ticks and wait until every result is back
	task automatic drain();
		tick_valid <= 1'b0;
		while (mirror.results_due() != 0)
			@(posedge clk);
	endtask

	// Write the whole register set; spare upper bits carry junk
	task automatic load_config(input ffm_pkg::cfg_t c);
		logic [31:0] d;
		for (ffm_pkg::cfg_idx_t idx = ffm_pkg::CFG_SENSOR_TIMEOUT;
				idx <= ffm_pkg::CFG_ALTITUDE_LOW; idx++) begin
			case (idx)
				ffm_pkg::CFG_SENSOR_TIMEOUT:   d = c.sensor_timeout_us;
				ffm_pkg::CFG_ATTITUDE_RECOVER: d = c.attitude_recovery_us;
				ffm_pkg::CFG_MAX_ROLL:         d = {17'($urandom), c.max_roll};
				ffm_pkg::CFG_MAX_PITCH:        d = {17'($urandom), c.max_pitch};
				ffm_pkg::CFG_POSITION_BOUND:   d = {1'($urandom), c.position_bound};
				ffm_pkg::CFG_ALTITUDE_HIGH:    d = c.altitude_high;
				ffm_pkg::CFG_ALTITUDE_LOW:     d = c.altitude_low;
				default:                       d = '0;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			mirror.set_reg(idx, d);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n, input bit noisy);
		for (int i = 0; i < n; i++)
			send_tick(random_tick(noisy));
	endtask

	initial begin
		ffm_pkg::cfg_t  c;
		ffm_pkg::tick_t t;
		abort_cause_t   cause;
		logic [31:0]    bound;
		clk = 1'b0;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick_bus = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ffm_pkg::CFG_SENSOR_TIMEOUT;
		cfg_data = '0;
		send_idle_pct = 17;
		stall_pct = 47;
		hold_request = 0;
		hold_left = 0;
		quiet_cycles = 0;
		imu_down = 1'b0;
		tilt_on = 1'b0;
		mirror = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register values straight out of reset
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0));
		send_tick(mk_tick({1'b0, ffm_pkg::RST_POSITION_BOUND},
			-{1'b0, ffm_pkg::RST_POSITION_BOUND}, ffm_pkg::RST_ALTITUDE_LOW,
			16'd6434, -16'sd6434, 16'd77, 1'b1, 1'b1, 16'd999));
		drain();

		// Directed: field extremes, strict threshold compares, mode priority
		c = CFG_AT_RESET;
		c.sensor_timeout_us = 100;
		c.attitude_recovery_us = 200;
		c.position_bound = '1;
		c.altitude_high = 32'h7FFF_FFFF;
		c.altitude_low = 32'h8000_0000;
		load_config(c);
		send_tick(mk_tick(32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0, 16'h7FFF,
			1'b1, 1'b1, 0));
		send_tick(mk_tick(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'h8000,
			1'b1, 1'b1, 16'hFFFF));
		send_tick(mk_tick(5, 6, 7, 0, 0, 16'h1234, 1'b0, 1'b1, 16'd100));
		send_tick(mk_tick(5, 6, 7, 0, 0, 16'h1234, 1'b0, 1'b1, 16'd0));
		// loss timer one above the timeout: descent, z and yaw zeroed
		send_tick(mk_tick(5, 6, 123456, 0, 0, 16'h1234, 1'b0, 1'b1, 16'd1));
		send_tick(mk_tick(5, 6, 7, 0, 0, 16'h1234, 1'b1, 1'b1, 16'd50));
		send_tick(mk_tick(1, 2, 3, 16'd6434, -16'sd6434, 16'd9, 1'b1, 1'b1, 16'd500));
		send_tick(mk_tick(1, 2, 3, 16'd6435, 0, 16'd9, 1'b1, 1'b1, 16'd200));
		send_tick(mk_tick(1, 2, 3, 16'd6435, 0, 16'd9, 1'b1, 1'b1, 16'd1));
		send_tick(mk_tick(1, 2, 3, 0, 16'h8000, 16'd9, 1'b1, 1'b1, 16'd0));
		send_tick(mk_tick(1, 2, 3, 0, -16'sd6435, 16'd9, 1'b0, 1'b1, 16'hFFFF));
		send_tick(mk_tick(1, 2, 3, 0, 0, 16'd9, 1'b1, 1'b1, 16'd3));
		drain();

		// Long timer run with every threshold at its maximum
		c.sensor_timeout_us = '1;
		c.attitude_recovery_us = '1;
		c.max_roll = '1;
		c.max_pitch = '1;
		load_config(c);
		for (int i = 0; i < SOAK_TICKS; i++) begin
			t = random_tick(1'b0);
			t.imu_ok = 1'b0;
			t.roll = 16'h8000;
			t.dt_us = '1;
			send_tick(t);
		end
		drain();
		c.sensor_timeout_us = 32'hFFFF_FFFE;
		c.attitude_recovery_us = 32'hFFFF_FFFE;
		load_config(c);
		send_tick(mk_tick(8, 8, 8, 16'h8000, 0, 16'd4, 1'b0, 1'b1, 16'hFFFF));
		send_tick(mk_tick(8, 8, 8, 16'h8000, 0, 16'd4, 1'b1, 1'b1, 16'd0));
		send_tick(mk_tick(8, 8, 8, 16'h7FFF, 16'h7FFF, 16'd4, 1'b1, 1'b1, 16'd10));
		send_tick(mk_tick(8, 8, 8, 0, 16'h8000, 16'd4, 1'b1, 1'b1, 16'd1));
		drain();

		// Random phases over three idling patterns and several settings
		send_idle_pct = 17;
		stall_pct = 47;
		load_config(random_config());
		run_random(PHASE_TICKS, 1'b0);
		drain();
		c.sensor_timeout_us = '0;
		c.attitude_recovery_us = '0;
		c.max_roll = '0;
		c.max_pitch = '0;
		c.position_bound = '1;
		c.altitude_high = 32'h7FFF_FFFF;
		c.altitude_low = 32'h8000_0000;
		load_config(c);
		run_random(PHASE_TICKS, 1'b0);
		drain();

		send_idle_pct = 47;
		stall_pct = 17;
		load_config(random_config());
		// long receiver hold-off while ticks keep coming: input must back up
		hold_request = 80;
		run_random(PHASE_TICKS, 1'b0);
		drain();
		c.sensor_timeout_us = '1;
		c.attitude_recovery_us = '1;
		c.max_roll = '1;
		c.max_pitch = '1;
		c.position_bound = '0;
		c.altitude_high = $urandom;
		c.altitude_low = c.altitude_high;
		load_config(c);
		run_random(PHASE_TICKS, 1'b0);
		drain();

		send_idle_pct = 0;
		stall_pct = 0;
		load_config(random_config());
		run_random(PHASE_TICKS, 1'b0);
		drain();
		load_config(CFG_AT_RESET);
		run_random(PHASE_TICKS, 1'b0);
		drain();

		// Abort last: it latches until reset, so one cause per run enters it
		cause = abort_cause_t'($urandom_range(0, 5));
		c = CFG_AT_RESET;
		if (cause == CAUSE_CROSSED_WINDOW) begin
			c.altitude_low = 32'h7FFF_FFFF;
			c.altitude_high = 32'h8000_0000;
		end
		load_config(c);
		bound = {1'b0, ffm_pkg::RST_POSITION_BOUND};
		if (cause != CAUSE_CROSSED_WINDOW) begin
			// box corners stay inside
			send_tick(mk_tick(bound, -bound, ffm_pkg::RST_ALTITUDE_HIGH, 0, 0, 16'd1,
				1'b1, 1'b1, 16'd10));
			send_tick(mk_tick(-bound, bound, ffm_pkg::RST_ALTITUDE_LOW, 0, 0, 16'd2,
				1'b1, 1'b1, 16'd10));
		end
		case (cause)
			CAUSE_STATE_BAD:
				t = mk_tick(11, 12, 13, 0, 0, 16'd3, 1'b1, 1'b0, 16'd10);
			CAUSE_X_MOST_NEG:
				t = mk_tick(32'h8000_0000, 12, 13, 0, 0, 16'd3, 1'b1, 1'b1, 16'd10);
			CAUSE_Y_OUT:
				t = mk_tick(11, bound + 1, 13, 0, 0, 16'd3, 1'b1, 1'b1, 16'd10);
			CAUSE_Z_HIGH:
				t = mk_tick(11, 12, ffm_pkg::RST_ALTITUDE_HIGH + 1, 0, 0, 16'd3,
					1'b1, 1'b1, 16'd10);
			CAUSE_Z_LOW:
				t = mk_tick(11, 12, ffm_pkg::RST_ALTITUDE_LOW - 1, 0, 0, 16'd3,
					1'b1, 1'b1, 16'd10);
			default:
				t = mk_tick(11, 12, 13, 0, 0, 16'd3, 1'b1, 1'b1, 16'd10);
		endcase
		send_tick(t);
		// latched: bad inputs, a would-be descent, then a clean tick
		send_tick(mk_tick(0, 32'h8000_0000, 5, 0, 0, 16'h8000, 1'b1, 1'b0, 16'd0));
		send_tick(mk_tick(21, 22, 23, 16'h8000, 16'h8000, 16'd5, 1'b0, 1'b1, 16'hFFFF));
		send_tick(mk_tick(21, 22, 23, 16'h8000, 0, 16'd5, 1'b0, 1'b1, 16'hFFFF));
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'h7FFF, 1'b1, 1'b1, 16'd1));
		run_random(80, 1'b1);
		drain();

		repeat (END_CYCLES) @(posedge clk);
		$display("Coverage: %0d results checked (nominal %0d, hover %0d, descent %0d, abort %0d)",
			mirror.n_checked, mirror.mode_count[ffm_pkg::MODE_NOMINAL],
			mirror.mode_count[ffm_pkg::MODE_HOVER], mirror.mode_count[ffm_pkg::MODE_DESCENT],
			mirror.mode_count[ffm_pkg::MODE_ABORT]);
		$display("Timers run long at maximum thresholds; abort entered by %s", cause.name());
		if (mirror.n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
